// ===== rtl/core/prc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_pkg
// shared constants, datapath operation codes and controller/datapath structs
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int unsigned MAX_PATCHES = 64;
    localparam int unsigned CNT_W       = $clog2(MAX_PATCHES + 1);
    localparam int unsigned ADDR_W      = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1;

    localparam int unsigned ELEM_W   = 32;
    localparam int unsigned SIZE_W   = 16;
    localparam int unsigned BYTE_W   = 48;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned OCNT_W   = 7;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned PROD_W   = BYTE_W + PCT_W;

    localparam logic [CNT_W-1:0]  MAX_CNT          = CNT_W'(MAX_PATCHES);
    localparam logic [PCT_W-1:0]  PERCENT_SCALE    = 7'd100;
    localparam logic [PCT_W-1:0]  COVERAGE_MAX     = 7'd100;
    localparam logic [SIZE_W-1:0] ELEM_SIZE_RESET  = 16'd16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MERGE_GAP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COPY_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COVERAGE      = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INS_RD,
        OP_INS_SHIFT,
        OP_INS_PLACE,
        OP_RUN_INIT,
        OP_M_RD,
        OP_M_MUL,
        OP_M_SUM,
        OP_M_TAKE,
        OP_M_MERGE,
        OP_M_CLOSE,
        OP_M_FLUSH,
        OP_FB_MUL1,
        OP_FB_MUL2,
        OP_FB_EVAL,
        OP_E_RD,
        OP_E_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic keep_in;
        logic last_in;
        logic last_pend;
        logic j_zero;
        logic gt;
        logic i_done;
        logic have_cur;
        logic joins;
        logic e_last;
    } dp_status_t;

endpackage

// ===== rtl/core/prc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module prc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/prc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_datapath
// config registers, patch store, merge arithmetic, fallback and result regs
// ----------------------------------------------------------------------------
module prc_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  prc_pkg::dp_cmd_t                   cmd,
    output prc_pkg::dp_status_t                status,
    input  logic                               cfg_we,
    input  logic [prc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [prc_pkg::CFG_W-1:0]          cfg_data,
    input  logic [prc_pkg::ELEM_W-1:0]         patch_begin,
    input  logic [prc_pkg::ELEM_W-1:0]         patch_length,
    input  logic                               last_patch,
    output logic                               result_valid,
    output logic [prc_pkg::BYTE_W-1:0]         range_offset,
    output logic [prc_pkg::BYTE_W-1:0]         range_size,
    output logic                               last_range,
    output logic                               no_ranges,
    output logic [prc_pkg::OCNT_W-1:0]         merged_count,
    output logic [prc_pkg::OCNT_W-1:0]         dropped_count,
    output logic [prc_pkg::BYTE_W-1:0]         merged_bytes,
    output logic                               fallback_full,
    output logic                               overflow
);

    localparam int unsigned KW = 2 * prc_pkg::ELEM_W;
    localparam int unsigned MW = 2 * prc_pkg::BYTE_W;

    // configuration
    logic [prc_pkg::ELEM_W-1:0] elem_count_reg;
    logic [prc_pkg::SIZE_W-1:0] elem_size_reg;
    logic [prc_pkg::ELEM_W-1:0] gap_reg;
    logic [prc_pkg::ELEM_W-1:0] copy_limit_reg;
    logic [prc_pkg::PCT_W-1:0]  coverage_reg;

    // run control
    logic [prc_pkg::CNT_W-1:0]  seen_reg;
    logic [prc_pkg::CNT_W-1:0]  kept_reg;
    logic [prc_pkg::CNT_W-1:0]  drop_reg;
    logic                       ovf_reg;
    logic                       last_reg;
    logic [prc_pkg::ADDR_W-1:0] j_reg;
    logic [prc_pkg::CNT_W-1:0]  i_reg;
    logic [prc_pkg::CNT_W-1:0]  count_reg;
    logic [prc_pkg::CNT_W-1:0]  k_reg;
    logic                       degen_reg;
    logic                       have_cur_reg;
    logic                       result_valid_reg;

    // payload
    logic [prc_pkg::ELEM_W-1:0] new_begin_reg;
    logic [prc_pkg::ELEM_W-1:0] new_len_reg;
    logic [prc_pkg::BYTE_W-1:0] lo_reg;
    logic [prc_pkg::BYTE_W-1:0] lenb_reg;
    logic [prc_pkg::BYTE_W-1:0] hi_reg;
    logic [prc_pkg::BYTE_W:0]   reach_reg;
    logic [prc_pkg::BYTE_W-1:0] cur_lo_reg;
    logic [prc_pkg::BYTE_W-1:0] cur_end_reg;
    logic [prc_pkg::BYTE_W-1:0] bytes_reg;
    logic [prc_pkg::BYTE_W-1:0] full_reg;
    logic [prc_pkg::PROD_W-1:0] bytes100_reg;
    logic [prc_pkg::PROD_W-1:0] fullp_reg;
    logic                       fb_reg;
    logic [prc_pkg::BYTE_W-1:0] range_offset_reg;
    logic [prc_pkg::BYTE_W-1:0] range_size_reg;
    logic                       last_range_reg;
    logic                       no_ranges_reg;
    logic [prc_pkg::OCNT_W-1:0] merged_count_reg;
    logic [prc_pkg::OCNT_W-1:0] dropped_count_reg;
    logic [prc_pkg::BYTE_W-1:0] merged_bytes_reg;
    logic                       fallback_full_reg;
    logic                       overflow_reg;

    // memories
    logic                       kram_we;
    logic [prc_pkg::ADDR_W-1:0] kram_waddr;
    logic [KW-1:0]              kram_wdata;
    logic [prc_pkg::ADDR_W-1:0] kram_raddr;
    logic [KW-1:0]              kram_rdata;
    logic                       mram_we;
    logic [MW-1:0]              mram_rdata;

    logic                       seen_full;
    logic                       keep_in;
    logic [prc_pkg::ELEM_W-1:0] room;
    logic [prc_pkg::ELEM_W-1:0] len_clamped;
    logic                       e_last;
    logic                       count_zero;
    logic [prc_pkg::PCT_W-1:0]  cfg_pct;

    assign seen_full   = (seen_reg >= prc_pkg::MAX_CNT);
    assign keep_in     = !seen_full && (patch_length != '0) && (patch_begin < elem_count_reg);
    assign room        = elem_count_reg - patch_begin;
    assign len_clamped = (patch_length < room) ? patch_length : room;
    assign count_zero  = (count_reg == '0);
    assign e_last      = count_zero || ((k_reg + prc_pkg::CNT_W'(1)) == count_reg);
    assign cfg_pct     = cfg_data[prc_pkg::PCT_W-1:0];

    always_comb
    begin
        status.keep_in   = keep_in;
        status.last_in   = last_patch;
        status.last_pend = last_reg;
        status.j_zero    = (j_reg == '0);
        status.gt        = (kram_rdata > {new_begin_reg, new_len_reg});
        status.i_done    = degen_reg || (i_reg == kept_reg);
        status.have_cur  = have_cur_reg;
        status.joins     = ({1'b0, lo_reg} <= reach_reg);
        status.e_last    = e_last;
    end

    // sorted patch store
    always_comb
    begin
        kram_we    = (cmd.op == prc_pkg::OP_INS_SHIFT) || (cmd.op == prc_pkg::OP_INS_PLACE);
        kram_waddr = j_reg;
        kram_wdata = (cmd.op == prc_pkg::OP_INS_SHIFT) ? kram_rdata
                                                       : {new_begin_reg, new_len_reg};
        kram_raddr = (cmd.op == prc_pkg::OP_M_RD) ? i_reg[prc_pkg::ADDR_W-1:0]
                                                  : j_reg - prc_pkg::ADDR_W'(1);
    end

    assign mram_we = (cmd.op == prc_pkg::OP_M_CLOSE) || (cmd.op == prc_pkg::OP_M_FLUSH);

    prc_ram #(
        .WIDTH (KW),
        .DEPTH (prc_pkg::MAX_PATCHES)
    ) u_kept_ram (
        .clk   (clk),
        .we    (kram_we),
        .waddr (kram_waddr),
        .wdata (kram_wdata),
        .raddr (kram_raddr),
        .rdata (kram_rdata)
    );

    prc_ram #(
        .WIDTH (MW),
        .DEPTH (prc_pkg::MAX_PATCHES)
    ) u_merged_ram (
        .clk   (clk),
        .we    (mram_we),
        .waddr (count_reg[prc_pkg::ADDR_W-1:0]),
        .wdata ({cur_lo_reg, cur_end_reg}),
        .raddr (k_reg[prc_pkg::ADDR_W-1:0]),
        .rdata (mram_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_count_reg   <= '0;
            elem_size_reg    <= prc_pkg::ELEM_SIZE_RESET;
            gap_reg          <= '0;
            copy_limit_reg   <= '0;
            coverage_reg     <= '0;
            seen_reg         <= '0;
            kept_reg         <= '0;
            drop_reg         <= '0;
            ovf_reg          <= 1'b0;
            last_reg         <= 1'b0;
            j_reg            <= '0;
            i_reg            <= '0;
            count_reg        <= '0;
            k_reg            <= '0;
            degen_reg        <= 1'b0;
            have_cur_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    prc_pkg::REG_ELEMENT_COUNT: elem_count_reg <= cfg_data;
                    prc_pkg::REG_ELEMENT_SIZE:  elem_size_reg  <= cfg_data[prc_pkg::SIZE_W-1:0];
                    prc_pkg::REG_MERGE_GAP:     gap_reg        <= cfg_data;
                    prc_pkg::REG_COPY_LIMIT:    copy_limit_reg <= cfg_data;
                    prc_pkg::REG_COVERAGE:
                        coverage_reg <= (cfg_pct > prc_pkg::COVERAGE_MAX) ? prc_pkg::COVERAGE_MAX
                                                                          : cfg_pct;
                    default: ;
                endcase
            end
            case (cmd.op)
                prc_pkg::OP_LOAD:
                begin
                    last_reg <= last_patch;
                    if (seen_full)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        seen_reg <= seen_reg + prc_pkg::CNT_W'(1);
                        if (keep_in)
                        begin
                            j_reg <= kept_reg[prc_pkg::ADDR_W-1:0];
                        end
                        else
                        begin
                            drop_reg <= drop_reg + prc_pkg::CNT_W'(1);
                        end
                    end
                end
                prc_pkg::OP_INS_SHIFT: j_reg    <= j_reg - prc_pkg::ADDR_W'(1);
                prc_pkg::OP_INS_PLACE: kept_reg <= kept_reg + prc_pkg::CNT_W'(1);
                prc_pkg::OP_RUN_INIT:
                begin
                    i_reg        <= '0;
                    count_reg    <= '0;
                    k_reg        <= '0;
                    have_cur_reg <= 1'b0;
                    degen_reg    <= (elem_count_reg == '0) || (elem_size_reg == '0);
                end
                prc_pkg::OP_M_RD:    i_reg        <= i_reg + prc_pkg::CNT_W'(1);
                prc_pkg::OP_M_TAKE:  have_cur_reg <= 1'b1;
                prc_pkg::OP_M_CLOSE: count_reg    <= count_reg + prc_pkg::CNT_W'(1);
                prc_pkg::OP_M_FLUSH: count_reg    <= count_reg + prc_pkg::CNT_W'(1);
                prc_pkg::OP_E_OUT:
                begin
                    result_valid_reg <= 1'b1;
                    k_reg            <= k_reg + prc_pkg::CNT_W'(1);
                    if (e_last)
                    begin
                        seen_reg <= '0;
                        kept_reg <= '0;
                        drop_reg <= '0;
                        ovf_reg  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            prc_pkg::OP_LOAD:
            begin
                new_begin_reg <= patch_begin;
                new_len_reg   <= len_clamped;
            end
            prc_pkg::OP_RUN_INIT: bytes_reg <= '0;
            prc_pkg::OP_M_MUL:
            begin
                lo_reg   <= prc_pkg::BYTE_W'(kram_rdata[KW-1:prc_pkg::ELEM_W])
                            * prc_pkg::BYTE_W'(elem_size_reg);
                lenb_reg <= prc_pkg::BYTE_W'(kram_rdata[prc_pkg::ELEM_W-1:0])
                            * prc_pkg::BYTE_W'(elem_size_reg);
            end
            prc_pkg::OP_M_SUM:
            begin
                hi_reg    <= lo_reg + lenb_reg;
                reach_reg <= {1'b0, cur_end_reg} + (prc_pkg::BYTE_W + 1)'(gap_reg);
            end
            prc_pkg::OP_M_TAKE:
            begin
                cur_lo_reg  <= lo_reg;
                cur_end_reg <= hi_reg;
            end
            prc_pkg::OP_M_MERGE:
            begin
                if (hi_reg > cur_end_reg)
                begin
                    cur_end_reg <= hi_reg;
                end
            end
            prc_pkg::OP_M_CLOSE:
            begin
                bytes_reg   <= bytes_reg + cur_end_reg - cur_lo_reg;
                cur_lo_reg  <= lo_reg;
                cur_end_reg <= hi_reg;
            end
            prc_pkg::OP_M_FLUSH: bytes_reg <= bytes_reg + cur_end_reg - cur_lo_reg;
            prc_pkg::OP_FB_MUL1:
            begin
                full_reg     <= prc_pkg::BYTE_W'(elem_count_reg)
                                * prc_pkg::BYTE_W'(elem_size_reg);
                bytes100_reg <= prc_pkg::PROD_W'(bytes_reg)
                                * prc_pkg::PROD_W'(prc_pkg::PERCENT_SCALE);
            end
            prc_pkg::OP_FB_MUL2:
                fullp_reg <= prc_pkg::PROD_W'(full_reg) * prc_pkg::PROD_W'(coverage_reg);
            prc_pkg::OP_FB_EVAL:
                fb_reg <= (full_reg != '0) &&
                          (count_zero || (bytes_reg >= full_reg) ||
                           ((copy_limit_reg != '0) &&
                            (prc_pkg::ELEM_W'(count_reg) >= copy_limit_reg)) ||
                           ((coverage_reg != '0) && (bytes100_reg >= fullp_reg)));
            prc_pkg::OP_E_OUT:
            begin
                range_offset_reg  <= count_zero ? '0 : mram_rdata[MW-1:prc_pkg::BYTE_W];
                range_size_reg    <= count_zero ? '0 : (mram_rdata[prc_pkg::BYTE_W-1:0]
                                                        - mram_rdata[MW-1:prc_pkg::BYTE_W]);
                last_range_reg    <= e_last;
                no_ranges_reg     <= count_zero;
                merged_count_reg  <= prc_pkg::OCNT_W'(count_reg);
                dropped_count_reg <= degen_reg ? '0 : prc_pkg::OCNT_W'(drop_reg);
                merged_bytes_reg  <= bytes_reg;
                fallback_full_reg <= fb_reg;
                overflow_reg      <= ovf_reg;
            end
            default: ;
        endcase
    end

    assign result_valid  = result_valid_reg;
    assign range_offset  = range_offset_reg;
    assign range_size    = range_size_reg;
    assign last_range    = last_range_reg;
    assign no_ranges     = no_ranges_reg;
    assign merged_count  = merged_count_reg;
    assign dropped_count = dropped_count_reg;
    assign merged_bytes  = merged_bytes_reg;
    assign fallback_full = fallback_full_reg;
    assign overflow      = overflow_reg;

endmodule

// ===== rtl/core/prc_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_controller
// sequencer for load, insertion sort, merge, fallback and result phases
// ----------------------------------------------------------------------------
module prc_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  prc_pkg::dp_status_t status,
    output prc_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INIT,
        S_M_RD,
        S_M_MUL,
        S_M_SUM,
        S_M_ACC,
        S_FLUSH,
        S_FB1,
        S_FB2,
        S_FB3,
        S_E_RD,
        S_E_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = prc_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = prc_pkg::OP_LOAD;
                    if (status.keep_in)
                    begin
                        state_next = S_INS_RD;
                    end
                    else if (status.last_in)
                    begin
                        // a patch that is not stored but closes the list starts the merge
                        state_next = S_INIT;
                    end
                end
            end
            S_INS_RD:
            begin
                if (status.j_zero)
                begin
                    cmd.op     = prc_pkg::OP_INS_PLACE;
                    state_next = status.last_pend ? S_INIT : S_IDLE;
                end
                else
                begin
                    cmd.op     = prc_pkg::OP_INS_RD;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (status.gt)
                begin
                    cmd.op     = prc_pkg::OP_INS_SHIFT;
                    state_next = S_INS_RD;
                end
                else
                begin
                    cmd.op     = prc_pkg::OP_INS_PLACE;
                    state_next = status.last_pend ? S_INIT : S_IDLE;
                end
            end
            S_INIT:
            begin
                cmd.op     = prc_pkg::OP_RUN_INIT;
                state_next = S_M_RD;
            end
            S_M_RD:
            begin
                if (status.i_done)
                begin
                    state_next = status.have_cur ? S_FLUSH : S_FB1;
                end
                else
                begin
                    cmd.op     = prc_pkg::OP_M_RD;
                    state_next = S_M_MUL;
                end
            end
            S_M_MUL:
            begin
                cmd.op     = prc_pkg::OP_M_MUL;
                state_next = S_M_SUM;
            end
            S_M_SUM:
            begin
                cmd.op     = prc_pkg::OP_M_SUM;
                state_next = S_M_ACC;
            end
            S_M_ACC:
            begin
                if (!status.have_cur)
                begin
                    cmd.op = prc_pkg::OP_M_TAKE;
                end
                else if (status.joins)
                begin
                    cmd.op = prc_pkg::OP_M_MERGE;
                end
                else
                begin
                    cmd.op = prc_pkg::OP_M_CLOSE;
                end
                state_next = S_M_RD;
            end
            S_FLUSH:
            begin
                cmd.op     = prc_pkg::OP_M_FLUSH;
                state_next = S_FB1;
            end
            S_FB1:
            begin
                cmd.op     = prc_pkg::OP_FB_MUL1;
                state_next = S_FB2;
            end
            S_FB2:
            begin
                cmd.op     = prc_pkg::OP_FB_MUL2;
                state_next = S_FB3;
            end
            S_FB3:
            begin
                cmd.op     = prc_pkg::OP_FB_EVAL;
                state_next = S_E_RD;
            end
            S_E_RD:
            begin
                cmd.op     = prc_pkg::OP_E_RD;
                state_next = S_E_OUT;
            end
            S_E_OUT:
            begin
                cmd.op     = prc_pkg::OP_E_OUT;
                state_next = status.e_last ? S_IDLE : S_E_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

// ===== rtl/core/patch_range_coalescer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patch_range_coalescer_top
// collects element patches, sorts and merges them into byte ranges, reports
// ----------------------------------------------------------------------------
// a dropped patch is only loaded; a stored patch is loaded, then placed at once
//   if it lands at the front of the store, else reads and compares each entry,
//   shifting larger ones up (insertion sort via the patch store's single read port)
// after the last patch: setup; a read, multiply, sum and accumulate per stored
//   patch; a finish; a flush to close an open range; the fallback steps; then
//   a read and an output per result; sequential, next patch waits for busy low
// results cannot be stalled; each is shown for exactly one cycle
// reset clears control state and loads register defaults; no clearing pass
// ----------------------------------------------------------------------------
module patch_range_coalescer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [prc_pkg::ELEM_W-1:0]    patch_begin,
    input  logic [prc_pkg::ELEM_W-1:0]    patch_length,
    input  logic                          last_patch,
    input  logic                          cfg_we,
    input  logic [prc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [prc_pkg::CFG_W-1:0]     cfg_data,
    output logic                          result_valid,
    output logic [prc_pkg::BYTE_W-1:0]    range_offset,
    output logic [prc_pkg::BYTE_W-1:0]    range_size,
    output logic                          last_range,
    output logic                          no_ranges,
    output logic [prc_pkg::OCNT_W-1:0]    merged_count,
    output logic [prc_pkg::OCNT_W-1:0]    dropped_count,
    output logic [prc_pkg::BYTE_W-1:0]    merged_bytes,
    output logic                          fallback_full,
    output logic                          overflow
);

    // command and status between sequencer and datapath
    prc_pkg::dp_cmd_t    cmd;
    prc_pkg::dp_status_t status;

    // sequencer: decides which datapath operation runs each cycle
    prc_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // datapath: config, patch store, merge arithmetic and result registers
    prc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .patch_begin   (patch_begin),
        .patch_length  (patch_length),
        .last_patch    (last_patch),
        .result_valid  (result_valid),
        .range_offset  (range_offset),
        .range_size    (range_size),
        .last_range    (last_range),
        .no_ranges     (no_ranges),
        .merged_count  (merged_count),
        .dropped_count (dropped_count),
        .merged_bytes  (merged_bytes),
        .fallback_full (fallback_full),
        .overflow      (overflow)
    );

    // a transfer out always comes from a running sequence
    a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe outside a run");

    // more results follow, so the block must still be busy
    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_range |-> busy)
        else $error("block idle before the final result");

    // an empty run gives exactly one result
    a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && no_ranges |-> last_range && (merged_count == '0))
        else $error("empty run result not final");

    // the datapath loads a patch only on an accepted transfer
    a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == prc_pkg::OP_LOAD) |-> (start && !busy))
        else $error("patch load without accepted transfer");

endmodule
